/* src/tvfs_pkg.sv */
// shared types and constants for the trilinear vector field sampler
package tvfs_pkg;

  localparam int unsigned CompW = 24;
  localparam int unsigned CoordW = 23;
  localparam int unsigned SizeW = 6;
  localparam int unsigned IdxW = 5;
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_POINT = 2'd1,
    KIND_TRI   = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SIZE_X = 2'd0,
    CFG_SIZE_Y = 2'd1,
    CFG_SIZE_Z = 2'd2,
    CFG_NONE   = 2'd3
  } cfg_idx_e;

  // control travelling along the pipeline with each item
  typedef struct packed {
    logic valid;
    logic trilin;
    logic ok;
  } ctl_t;

  typedef logic signed [CompW-1:0] comp_t;

endpackage

/* src/tvfs_lerp.sv */
// one registered lerp stage a + floor((b - a) * f / 2^frac)
module tvfs_lerp import tvfs_pkg::*; #(
  parameter int unsigned FracBits = 16
) (
  input  logic                clk_i,
  input  comp_t               a_i,
  input  comp_t               b_i,
  input  logic [FracBits-1:0] f_i,
  output comp_t               y_o
);

  logic signed [CompW:0]            diff;
  logic signed [CompW+FracBits+1:0] prod;
  logic signed [CompW+FracBits+1:0] sum;

  assign diff = {b_i[CompW-1], b_i} - {a_i[CompW-1], a_i};
  assign prod = diff * $signed({1'b0, f_i});
  assign sum  = (prod >>> FracBits) + (CompW+FracBits+2)'(a_i);

  always_ff @(posedge clk_i) begin
    y_o <= sum[CompW-1:0];
  end

endmodule

/* src/tvfs_bank.sv */
// one parity bank of the voxel store, one component set per entry
module tvfs_bank import tvfs_pkg::*; #(
  parameter int unsigned AddrW = 12
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrW-1:0]    waddr_i,
  input  logic [3*CompW-1:0]  wdata_i,
  input  logic [AddrW-1:0]    raddr_i,
  output logic [3*CompW-1:0]  rdata_o
);

  logic [3*CompW-1:0] mem [2**AddrW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

/* src/trilinear_vector_field_sampler.sv */
// top level of the trilinear vector field sampler
// usage:
//   a command is taken on any cycle with start high and busy low; busy
//   is always low, so one item enters per clock, back to back
//   kind_i write stores value_*_i at write_*_i and gives no result
//   kind_i point or trilinear gives one result; done rises when the item
//   reaches ctl6_q, and the result is taken at the edge after that
//   the voxel store is split into eight banks by index parity, so the eight
//   corners of a trilinear cell come from eight separate banks in one read
//   the pipeline: address/range check, bank read, select, x lerps,
//   y lerps, z lerp
//   a point query runs down the same pipe with zero fractions, all corners
//   taken from its own voxel
//   cfg_we_i writes size registers; writes only while idle
//   reset clears the valid bits and sets sizes to their maximum; voxel
//   contents stay undefined until written
//   the receiver cannot stall: a result shows for exactly one cycle
module trilinear_vector_field_sampler import tvfs_pkg::*; #(
  parameter int unsigned MAX_DIM   = 32,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  output logic                    done,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxW-1:0]      cfg_idx_i,
  input  logic [SizeW-1:0]        cfg_data_i,
  input  logic [1:0]              kind_i,
  input  logic [IdxW-1:0]         write_x_i,
  input  logic [IdxW-1:0]         write_y_i,
  input  logic [IdxW-1:0]         write_z_i,
  input  logic signed [CompW-1:0] value_x_i,
  input  logic signed [CompW-1:0] value_y_i,
  input  logic signed [CompW-1:0] value_z_i,
  input  logic signed [CoordW-1:0] coord_x_i,
  input  logic signed [CoordW-1:0] coord_y_i,
  input  logic signed [CoordW-1:0] coord_z_i,
  output logic signed [CompW-1:0] out_x_o,
  output logic signed [CompW-1:0] out_y_o,
  output logic signed [CompW-1:0] out_z_o,
  output logic                    in_range_o
);

  localparam int unsigned DimW  = $clog2(MAX_DIM);
  localparam int unsigned HalfW = (DimW > 1) ? DimW - 1 : 1;
  localparam int unsigned BankAW = 3 * HalfW;
  localparam int unsigned IntW  = CoordW - FRAC_BITS;

  typedef logic [FRAC_BITS-1:0] frac_t;

  assign busy = 1'b0;

  // size registers, clamped to MAX_DIM on use
  logic [SizeW-1:0] size_q [3];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q[0] <= SizeW'(32);
      size_q[1] <= SizeW'(32);
      size_q[2] <= SizeW'(32);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SIZE_X: size_q[0] <= cfg_data_i;
        CFG_SIZE_Y: size_q[1] <= cfg_data_i;
        CFG_SIZE_Z: size_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic accept;
  assign accept = start && !busy;

  // ---- stage 1: range check, corner bank addresses ----
  logic signed [CoordW-1:0] coord [3];
  assign coord[0] = coord_x_i;
  assign coord[1] = coord_y_i;
  assign coord[2] = coord_z_i;

  logic [2:0]         ok_ax;
  frac_t              fr [3];
  logic [IntW-1:0]    ip [3];
  logic [IntW:0]      ip1 [3];
  logic [8:0]         effsz [3];
  // per axis: base half index, odd flag
  logic [HalfW-1:0]   lo_h [3];
  logic [HalfW-1:0]   hi_h [3];
  logic [2:0]         odd;
  logic               is_tri;

  assign is_tri = (kind_i == KIND_TRI);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      effsz[k] = (size_q[k] > SizeW'(MAX_DIM)) ? 9'(MAX_DIM) : 9'(size_q[k]);
      ip[k]  = coord[k][CoordW-1:FRAC_BITS];
      fr[k]  = coord[k][FRAC_BITS-1:0];
      ip1[k] = {1'b0, ip[k]} + (IntW+1)'(is_tri);
      ok_ax[k] = !coord[k][CoordW-1] && (9'(ip1[k]) < effsz[k])
                 && ((IntW + 1) <= 9 || ip1[k] < (IntW+1)'(effsz[k]));
      odd[k] = ip[k][0];
      // even corner half-index: for odd base, even neighbor is ip+1
      lo_h[k] = HalfW'(ip[k] >> 1);
      hi_h[k] = HalfW'((ip[k] + IntW'(1)) >> 1);
    end
  end

  ctl_t ctl1_q, ctl2_q, ctl3_q, ctl4_q, ctl5_q, ctl6_q;
  logic [2:0]         odd1_q, odd2_q;
  frac_t              fr1_q [3];
  frac_t              fr2_q [3];
  frac_t              fr3_q [3];
  frac_t              fr4_q [3];
  frac_t              fr5_q [3];
  logic [BankAW-1:0]  raddr_q [8];

  // bank b holds voxels whose index parities equal b (bit0 x, bit1 y, bit2 z)
  always_ff @(posedge clk_i) begin
    for (int b = 0; b < 8; b++) begin
      logic [HalfW-1:0] hx, hy, hz;
      hx = (b[0] == odd[0]) ? lo_h[0] : hi_h[0];
      hy = (b[1] == odd[1]) ? lo_h[1] : hi_h[1];
      hz = (b[2] == odd[2]) ? lo_h[2] : hi_h[2];
      raddr_q[b] <= {hz, hy, hx};
    end
    odd1_q <= odd;
    for (int k = 0; k < 3; k++) begin
      fr1_q[k] <= is_tri ? fr[k] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
    end else begin
      ctl1_q.valid  <= accept && (kind_i == KIND_POINT || kind_i == KIND_TRI);
      ctl1_q.trilin <= is_tri;
      ctl1_q.ok     <= &ok_ax;
    end
  end

  // write path into the banks
  logic               wr_en;
  logic [2:0]         wr_bank;
  logic [BankAW-1:0]  wr_addr;
  assign wr_en   = accept && (kind_i == KIND_WRITE) &&
                   (32'(write_x_i) < MAX_DIM) && (32'(write_y_i) < MAX_DIM) &&
                   (32'(write_z_i) < MAX_DIM);
  assign wr_bank = {write_z_i[0], write_y_i[0], write_x_i[0]};
  assign wr_addr = {HalfW'(write_z_i >> 1), HalfW'(write_y_i >> 1),
                    HalfW'(write_x_i >> 1)};

  // ---- stage 2: bank read ----
  logic [3*CompW-1:0] rdata [8];
  for (genvar b = 0; b < 8; b++) begin : g_bank
    tvfs_bank #(.AddrW(BankAW)) u_bank (
      .clk_i   (clk_i),
      .we_i    (wr_en && (wr_bank == 3'(b))),
      .waddr_i (wr_addr),
      .wdata_i ({value_z_i, value_y_i, value_x_i}),
      .raddr_i (raddr_q[b]),
      .rdata_o (rdata[b])
    );
  end

  always_ff @(posedge clk_i) begin
    odd2_q <= odd1_q;
    fr2_q  <= fr1_q;
  end

  // ---- stage 3: map banks to cell corners ----
  // a point query feeds its own voxel to every corner, so neighbors never matter
  comp_t corner_q [8][3];
  always_ff @(posedge clk_i) begin
    for (int n = 0; n < 8; n++) begin
      for (int c = 0; c < 3; c++) begin
        corner_q[n][c] <= rdata[(ctl2_q.trilin ? 3'(n) : 3'd0) ^ odd2_q][c*CompW +: CompW];
      end
    end
    fr3_q <= fr2_q;
  end

  // ---- stages 4..6: lerps along x, y, z ----
  comp_t xl [4][3];
  comp_t yl [2][3];
  comp_t zl [3];
  for (genvar c = 0; c < 3; c++) begin : g_comp
    for (genvar j = 0; j < 4; j++) begin : g_x
      tvfs_lerp #(.FracBits(FRAC_BITS)) u_lx (
        .clk_i(clk_i), .a_i(corner_q[2*j][c]), .b_i(corner_q[2*j+1][c]),
        .f_i(fr3_q[0]), .y_o(xl[j][c]));
    end
    for (genvar j = 0; j < 2; j++) begin : g_y
      tvfs_lerp #(.FracBits(FRAC_BITS)) u_ly (
        .clk_i(clk_i), .a_i(xl[2*j][c]), .b_i(xl[2*j+1][c]),
        .f_i(fr4_q[1]), .y_o(yl[j][c]));
    end
    tvfs_lerp #(.FracBits(FRAC_BITS)) u_lz (
      .clk_i(clk_i), .a_i(yl[0][c]), .b_i(yl[1][c]),
      .f_i(fr5_q[2]), .y_o(zl[c]));
  end

  always_ff @(posedge clk_i) begin
    fr4_q <= fr3_q;
    fr5_q <= fr4_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl2_q <= '0;
      ctl3_q <= '0;
      ctl4_q <= '0;
      ctl5_q <= '0;
      ctl6_q <= '0;
    end else begin
      ctl2_q <= ctl1_q;
      ctl3_q <= ctl2_q;
      ctl4_q <= ctl3_q;
      ctl5_q <= ctl4_q;
      ctl6_q <= ctl5_q;
    end
  end

  assign done       = ctl6_q.valid;
  assign in_range_o = ctl6_q.ok;
  assign out_x_o    = ctl6_q.ok ? zl[0] : '0;
  assign out_y_o    = ctl6_q.ok ? zl[1] : '0;
  assign out_z_o    = ctl6_q.ok ? zl[2] : '0;

`ifndef SYNTHESIS
  a_busy_low: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> $past(ctl1_q.valid, 5)) else $error("result without query");
  a_zero_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done && !in_range_o) |-> (out_x_o == '0 && out_y_o == '0 && out_z_o == '0))
    else $error("nonzero out of range result");
`endif

endmodule
